/* sv/fba_pkg.sv */
// Package: shared constants, types and helpers for the block allocator
`timescale 1ns / 1ps
`default_nettype none
package fba_pkg;
   localparam int Banks = 4;
   localparam int BlocksPerBank = 1024;
   localparam int PagesPerBlock = 128;
   localparam int BankW = (Banks > 1) ? $clog2(Banks) : 1;
   localparam int BlkW = $clog2(BlocksPerBank);
   localparam int AddrW = BankW + BlkW;
   localparam int SlotW = BankW + 1;
   localparam int Slots = 2 * Banks;
   localparam int CntW = 8;
   localparam int LimitI = (PagesPerBlock - 1 > 255) ? 255 : PagesPerBlock - 1;
   localparam logic [CntW-1:0] CountLimit = CntW'(LimitI);
   localparam logic [9:0] HotSizeReset = 10'd60;

   typedef enum logic [2:0] {
      MODE_LOAD = 3'd0, MODE_ALLOC = 3'd1, MODE_INC = 3'd2,
      MODE_DEC = 3'd3, MODE_COLLECT = 3'd4, MODE_PUSH = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_LIMIT = 2'd2, ST_ZERO = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_HOT = 2'd0, CSR_ENTRIES = 2'd1, CSR_THRESH = 2'd2
   } csr_index_type;

   // top-level sequencer states
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD1, S_RD2, S_CNT, S_CNTW, S_SCAN, S_SW1, S_SW2,
      S_SW3, S_PUSH, S_RESP
   } state_type;

   // scan engine states
   typedef enum logic [2:0] {SC_IDLE, SC_RDL, SC_RDC, SC_CMP, SC_DONE} sc_state_type;

   // scan engine control and results
   typedef struct packed {
      logic             start;
      logic [BankW-1:0] bank;
      logic [10:0]      offset;
      logic [10:0]      size;
      logic [10:0]      tail;
      logic [10:0]      rsv;
   } scan_cmd_type;

   typedef struct packed {
      logic            done;
      logic [10:0]     best;
      logic [CntW-1:0] best_cnt;
   } scan_res_type;
endpackage
`default_nettype wire

/* sv/fba_scan.sv */
// Victim search: walks the ring one slot at a time through a shared compare
`timescale 1ns / 1ps
`default_nettype none
module fba_scan
   import fba_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire scan_cmd_type    cmd,
   output logic [AddrW-1:0]     list_addr,
   input  wire logic [BlkW-1:0] list_data,
   output logic [AddrW-1:0]     cnt_addr,
   input  wire logic [CntW-1:0] cnt_data,
   output scan_res_type         res
);
   sc_state_type state_ff, state_in;
   logic [10:0] pos_ff, pos_in, n_ff, n_in, best_ff, best_in;
   logic [CntW-1:0] bc_ff, bc_in;
   logic first_ff, first_in;
   logic [10:0] nxt;
   logic [11:0] sum;

   assign nxt = (pos_ff + 11'd1 >= cmd.size) ? 11'd0 : pos_ff + 11'd1;
   assign sum = {1'b0, cmd.offset} + {1'b0, pos_ff};
   assign list_addr = {cmd.bank, sum[BlkW-1:0]};
   assign cnt_addr = {cmd.bank, list_data};
   assign res.done = (state_ff == SC_DONE);
   assign res.best = best_ff;
   assign res.best_cnt = bc_ff;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) state_ff <= SC_IDLE;
      else state_ff <= state_in;
      pos_ff <= pos_in; n_ff <= n_in; best_ff <= best_in;
      bc_ff <= bc_in; first_ff <= first_in;
   end

   // advance the walk: read list, read count, compare
   always_comb begin
      state_in = state_ff; pos_in = pos_ff; n_in = n_ff;
      best_in = best_ff; bc_in = bc_ff; first_in = first_ff;
      case (state_ff)
         SC_IDLE: begin
            if (cmd.start) begin
               pos_in = cmd.tail; n_in = 11'd0; best_in = cmd.tail;
               first_in = 1'b1; state_in = SC_RDL;
            end
         end
         SC_RDL: state_in = SC_RDC;
         SC_RDC: state_in = SC_CMP;
         SC_CMP: begin
            if (first_ff || cnt_data < bc_ff) begin
               bc_in = cnt_data; best_in = pos_ff;
            end
            first_in = 1'b0;
            if (!first_ff) n_in = n_ff + 11'd1;
            if (nxt == cmd.rsv || (!first_ff && n_ff + 11'd1 >= cmd.size)) begin
               state_in = SC_DONE;
            end else begin
               pos_in = nxt; state_in = SC_RDL;
            end
         end
         SC_DONE: state_in = SC_IDLE;
         default: state_in = SC_IDLE;
      endcase
   end
endmodule
`default_nettype wire

/* sv/flash_block_allocator_greedy_gc_unit.sv */
// Top level: block list allocator with greedy collection victim search
// One request at a time; busy is high while a request is in work and for
// one cycle after a size register write. After reset a clearing pass
// zeroes the valid counts; busy stays high during it. The receiver
// cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module flash_block_allocator_greedy_gc_unit
   import fba_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_mode,
   input  wire logic [1:0]  req_bank,
   input  wire logic        req_region,
   input  wire logic [9:0]  req_list_index,
   input  wire logic [9:0]  req_block_number,
   output logic             rsp_strobe,
   output logic [9:0]       rsp_result_block,
   output logic [7:0]       rsp_valid_count,
   output logic             rsp_gc_needed,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [10:0] csr_wdata
);
   localparam int Total = Banks * BlocksPerBank;

   logic [BlkW-1:0] list_mem [Total];
   logic [CntW-1:0] cnt_mem [Total];
   logic [BlkW-1:0] list_rd_ff;
   logic [CntW-1:0] cnt_rd_ff;
   logic [AddrW-1:0] la, ca;
   logic lwe, cwe;
   logic [BlkW-1:0] lwd;
   logic [CntW-1:0] cwd;

   logic [10:0] head_ff [Slots];
   logic [10:0] tail_ff [Slots];
   logic [10:0] rsv_ff [Slots];
   logic [10:0] free_ff [Slots];
   logic [9:0] hot_ff;
   logic [10:0] ent_ff, thr_ff;
   logic init_ff, init_in;

   state_type state_ff, state_in;
   logic [AddrW:0] clr_ff, clr_in;
   logic [2:0] mode_ff;
   logic [BankW-1:0] bank_ff;
   logic reg_ff;
   logic [9:0] lidx_ff, blk_ff;
   logic [9:0] rblk_ff, rblk_in, tmp_ff, tmp_in;
   logic [7:0] rcnt_ff, rcnt_in;
   status_type st_ff, st_in;
   logic [SlotW-1:0] pi_ff, pi_in;

   logic [10:0] e_use, h_use, sz0, sz1, size, off;
   logic [SlotW-1:0] s;
   scan_cmd_type cmd;
   scan_res_type sres;
   logic [AddrW-1:0] scan_la, scan_ca;
   logic upd_alloc, upd_coll;

   // derive region sizes from the clamped registers
   always_comb begin
      e_use = (ent_ff > 11'(BlocksPerBank)) ? 11'(BlocksPerBank) : ent_ff;
      if (e_use < 11'd2) e_use = 11'd2;
      h_use = {1'b0, hot_ff};
      if (h_use < 11'd1) h_use = 11'd1;
      if (h_use > e_use - 11'd1) h_use = e_use - 11'd1;
      sz0 = h_use;
      sz1 = e_use - h_use;
   end
   assign s = {bank_ff, reg_ff};
   assign size = reg_ff ? sz1 : sz0;
   assign off = reg_ff ? sz0 : 11'd0;

   function automatic logic [AddrW-1:0] laddr(input logic [BankW-1:0] b,
                                               input logic [10:0] o, input logic [10:0] p);
      logic [11:0] t;
      t = {1'b0, o} + {1'b0, p};
      return {b, t[BlkW-1:0]};
   endfunction

   assign cmd.start = (state_ff == S_RD2) && (mode_ff == MODE_COLLECT);
   assign cmd.bank = bank_ff;
   assign cmd.offset = off;
   assign cmd.size = size;
   assign cmd.tail = tail_ff[s];
   assign cmd.rsv = rsv_ff[s];

   fba_scan u_scan (
      .clock(clock), .reset(reset), .cmd(cmd), .list_addr(scan_la),
      .list_data(list_rd_ff), .cnt_addr(scan_ca), .cnt_data(cnt_rd_ff), .res(sres)
   );

   // memories
   always_ff @(posedge clock) begin
      if (lwe) list_mem[la] <= lwd;
      list_rd_ff <= list_mem[la];
      if (cwe) cnt_mem[ca] <= cwd;
      cnt_rd_ff <= cnt_mem[ca];
   end

   // take settings only while idle and no request is being taken
   assign busy = (state_ff != S_IDLE) || init_ff;
   assign csr_ready = (state_ff == S_IDLE) && !init_ff && !start;

   // sequencer
   always_comb begin
      state_in = state_ff; clr_in = clr_ff; rblk_in = rblk_ff; rcnt_in = rcnt_ff;
      st_in = st_ff; tmp_in = tmp_ff; pi_in = pi_ff;
      la = scan_la; ca = scan_ca; lwe = 1'b0; cwe = 1'b0;
      lwd = blk_ff; cwd = '0; upd_alloc = 1'b0; upd_coll = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            ca = clr_ff[AddrW-1:0]; cwe = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AddrW+1)'(Total - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            rblk_in = '0; rcnt_in = '0; st_in = ST_OK; pi_in = '0;
            if (start) state_in = S_RD1;
         end
         S_RD1: begin
            la = laddr(bank_ff, off, (mode_ff == MODE_ALLOC) ? head_ff[s] : tail_ff[s]);
            ca = {bank_ff, blk_ff};
            case (mode_ff)
               MODE_LOAD: begin
                  la = {bank_ff, lidx_ff}; lwe = 1'b1; rblk_in = blk_ff;
                  state_in = S_RESP;
               end
               MODE_ALLOC: begin
                  if (free_ff[s] == 11'd0) begin
                     st_in = ST_EMPTY; state_in = S_RESP;
                  end else state_in = S_RD2;
               end
               MODE_INC, MODE_DEC: state_in = S_CNT;
               MODE_COLLECT: begin
                  if (free_ff[s] >= size) begin
                     st_in = ST_EMPTY; state_in = S_RESP;
                  end else state_in = S_RD2;
               end
               MODE_PUSH: state_in = S_PUSH;
               default: state_in = S_RESP;
            endcase
         end
         S_RD2: begin
            if (mode_ff == MODE_ALLOC) begin
               rblk_in = list_rd_ff; upd_alloc = 1'b1; state_in = S_RESP;
            end else begin
               tmp_in = list_rd_ff; state_in = S_SCAN;
            end
         end
         S_CNT: begin
            ca = {bank_ff, blk_ff}; rblk_in = blk_ff;
            if (mode_ff == MODE_INC) begin
               if (cnt_rd_ff >= CountLimit) begin
                  st_in = ST_LIMIT; rcnt_in = cnt_rd_ff;
               end else begin
                  cwe = 1'b1; cwd = cnt_rd_ff + 8'd1; rcnt_in = cnt_rd_ff + 8'd1;
               end
            end else begin
               if (cnt_rd_ff == '0) st_in = ST_ZERO;
               else begin
                  cwe = 1'b1; cwd = cnt_rd_ff - 8'd1; rcnt_in = cnt_rd_ff - 8'd1;
               end
            end
            state_in = S_RESP;
         end
         S_SCAN: begin
            if (sres.done) begin
               rcnt_in = sres.best_cnt; state_in = S_SW1;
               la = laddr(bank_ff, off, sres.best);
               rblk_in = 10'(sres.best);
            end
         end
         S_SW1: begin
            // rblk holds best position; read victim block
            la = laddr(bank_ff, off, {1'b0, rblk_ff});
            state_in = S_SW2;
         end
         S_SW2: begin
            // write old tail block into best slot, remember victim
            la = laddr(bank_ff, off, {1'b0, rblk_ff}); lwe = 1'b1; lwd = tmp_ff;
            tmp_in = list_rd_ff; state_in = S_SW3;
         end
         S_SW3: begin
            la = laddr(bank_ff, off, tail_ff[s]); lwe = 1'b1; lwd = tmp_ff;
            ca = {bank_ff, tmp_ff}; cwe = 1'b1; cwd = '0;
            rblk_in = tmp_ff; upd_coll = 1'b1; state_in = S_RESP;
         end
         S_PUSH: begin
            pi_in = pi_ff + 1'b1;
            if (pi_ff == SlotW'(Slots - 1)) state_in = S_RESP;
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0;
         hot_ff <= HotSizeReset; ent_ff <= 11'd1024; thr_ff <= 11'd8;
         init_ff <= 1'b1;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; init_ff <= init_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HOT: hot_ff <= csr_wdata[9:0];
               CSR_ENTRIES: ent_ff <= csr_wdata;
               CSR_THRESH: thr_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end
   assign init_in = csr_valid && csr_ready &&
                    (csr_index == CSR_HOT || csr_index == CSR_ENTRIES);

   // payload and ring pointers
   always_ff @(posedge clock) begin
      rblk_ff <= rblk_in; rcnt_ff <= rcnt_in; st_ff <= st_in;
      tmp_ff <= tmp_in; pi_ff <= pi_in;
      if (start && !busy) begin
         mode_ff <= req_mode; bank_ff <= req_bank[BankW-1:0]; reg_ff <= req_region;
         lidx_ff <= req_list_index; blk_ff <= req_block_number;
      end
      for (int i = 0; i < Slots; i++) begin
         if (reset || init_ff) begin
            head_ff[i] <= '0; tail_ff[i] <= '0; rsv_ff[i] <= '0;
            free_ff[i] <= (i % 2 == 1) ? sz1 : sz0;
         end
      end
      if (!reset && !init_ff) begin
         if (upd_alloc) begin
            head_ff[s] <= (head_ff[s] + 11'd1 >= size) ? 11'd0 : head_ff[s] + 11'd1;
            free_ff[s] <= free_ff[s] - 11'd1;
         end
         if (upd_coll) begin
            tail_ff[s] <= (tail_ff[s] + 11'd1 >= size) ? 11'd0 : tail_ff[s] + 11'd1;
            free_ff[s] <= free_ff[s] + 11'd1;
         end
         if (state_ff == S_PUSH) begin
            rsv_ff[pi_ff] <= (head_ff[pi_ff] == 11'd0)
               ? (pi_ff[0] ? sz1 : sz0) - 11'd1 : head_ff[pi_ff] - 11'd1;
         end
      end
   end

   // one-cycle result
   assign rsp_strobe = (state_ff == S_RESP);
   assign rsp_result_block = rblk_ff;
   assign rsp_valid_count = rcnt_ff;
   assign rsp_gc_needed = free_ff[s] < thr_ff;
   assign rsp_status = st_ff;
endmodule
`default_nettype wire

/* sv/fba_checker.sv */
// Port checker for the allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module fba_checker
   import fba_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_strobe,
   input wire logic [7:0] rsp_valid_count,
   input wire logic [1:0] rsp_status
);
   // a result arrives only while a request is in work
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result without request");
   // accepted request makes the block busy
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not taken");
   // results are single-cycle
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("double result");
   // a zero status on decrement reports a zero count
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_ZERO) |-> rsp_valid_count == 8'd0)
      else $error("zero status with count");
endmodule

bind flash_block_allocator_greedy_gc_unit fba_checker u_fba_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_valid_count(rsp_valid_count), .rsp_status(rsp_status)
);
`default_nettype wire

/* tb/sv/tb_flash_block_allocator_greedy_gc_unit.sv */
// Testbench for the greedy collection block allocator: directed table, then checked random requests
`timescale 1ns / 1ps
`default_nettype none
module tb_flash_block_allocator_greedy_gc_unit;
   import fba_pkg::*;

   localparam logic [2:0] ModeSpare6 = 3'd6;
   localparam logic [2:0] ModeSpare7 = 3'd7;

   typedef struct packed {
      logic [2:0] mode;
      logic [1:0] bank;
      logic       region;
      logic [9:0] lidx;
      logic [9:0] blk;
   } req_type;

   typedef struct packed {
      logic [9:0] blk;
      logic [7:0] cnt;
      logic       gc;
      logic [1:0] st;
   } rsp_type;

   typedef struct packed {
      req_type q;
      bit      typed;
      rsp_type e;
   } dir_row_type;

   // directed rows at reset settings (hot 60, 1024 entries, threshold 8)
   localparam int DirRows = 12;
   localparam dir_row_type DirTable [DirRows] = '{
      '{'{MODE_INC,     2'd0, 1'b0, 10'd0,    10'd0},    1'b1, '{10'd0,    8'd1, 1'b0, ST_OK}},
      '{'{MODE_DEC,     2'd0, 1'b0, 10'd0,    10'd0},    1'b1, '{10'd0,    8'd0, 1'b0, ST_OK}},
      '{'{MODE_DEC,     2'd0, 1'b0, 10'd0,    10'd0},    1'b1, '{10'd0,    8'd0, 1'b0, ST_ZERO}},
      '{'{MODE_COLLECT, 2'd1, 1'b1, 10'd0,    10'd0},    1'b1, '{10'd0,    8'd0, 1'b0, ST_EMPTY}},
      '{'{MODE_LOAD,    2'd3, 1'b1, 10'd1023, 10'd1023}, 1'b1, '{10'd1023, 8'd0, 1'b0, ST_OK}},
      '{'{MODE_LOAD,    2'd0, 1'b0, 10'd0,    10'd0},    1'b1, '{10'd0,    8'd0, 1'b0, ST_OK}},
      '{'{ModeSpare6,   2'd2, 1'b1, 10'd1023, 10'd1023}, 1'b1, '{10'd0,    8'd0, 1'b0, ST_OK}},
      '{'{ModeSpare7,   2'd1, 1'b0, 10'd512,  10'd341},  1'b1, '{10'd0,    8'd0, 1'b0, ST_OK}},
      '{'{MODE_PUSH,    2'd0, 1'b0, 10'd0,    10'd0},    1'b1, '{10'd0,    8'd0, 1'b0, ST_OK}},
      '{'{MODE_INC,     2'd3, 1'b1, 10'd0,    10'd1023}, 1'b1, '{10'd1023, 8'd1, 1'b0, ST_OK}},
      '{'{MODE_DEC,     2'd2, 1'b1, 10'd682,  10'd512},  1'b1, '{10'd512,  8'd0, 1'b0, ST_ZERO}},
      '{'{MODE_COLLECT, 2'd3, 1'b0, 10'd0,    10'd0},    1'b0, '{10'd0,    8'd0, 1'b0, ST_OK}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_mode = '0;
   logic [1:0] req_bank = '0;
   logic req_region = 1'b0;
   logic [9:0] req_list_index = '0;
   logic [9:0] req_block_number = '0;
   logic rsp_strobe;
   logic [9:0] rsp_result_block;
   logic [7:0] rsp_valid_count;
   logic rsp_gc_needed;
   logic [1:0] rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [10:0] csr_wdata = '0;

   flash_block_allocator_greedy_gc_unit uut (.*);

   always #4 clock = ~clock;

   // allocator image kept alongside the block
   logic [9:0] lists [Banks*BlocksPerBank];
   bit         loaded [Banks*BlocksPerBank];
   int         pages [Banks*BlocksPerBank];
   int         head_pos [Slots];
   int         tail_pos [Slots];
   int         rsv_pos [Slots];
   int         free_cnt [Slots];
   int         hot_cfg = 60;
   int         entries_cfg = 1024;
   int         thresh_cfg = 8;
   rsp_type    pending [$];
   int         errors = 0;

   function automatic int region_len(bit r);
      int e = entries_cfg;
      int h = hot_cfg;
      if (e > BlocksPerBank) e = BlocksPerBank;
      if (e < 2) e = 2;
      if (h < 1) h = 1;
      if (h > e - 1) h = e - 1;
      return r ? e - h : h;
   endfunction

   function automatic int slot_addr(int bank, bit r, int pos);
      int off = r ? region_len(0) : 0;
      return bank * BlocksPerBank + (off + pos) % BlocksPerBank;
   endfunction

   function automatic int step_ring(int p, int len);
      return (p + 1 >= len) ? 0 : p + 1;
   endfunction

   function automatic void reset_rings();
      for (int i = 0; i < Slots; i++) begin
         head_pos[i] = 0;
         tail_pos[i] = 0;
         rsv_pos[i] = 0;
         free_cnt[i] = region_len(1'(i % 2));
      end
   endfunction

   // work out the response to one request and advance the image
   function automatic rsp_type allocate_step(req_type q);
      int s = q.bank * 2 + q.region;
      int len = region_len(q.region);
      int a, c, best, bestc, i, n;
      logic [9:0] swap;
      rsp_type o = '0;
      o.st = ST_OK;
      case (q.mode)
         MODE_LOAD: begin
            lists[q.bank * BlocksPerBank + q.lidx] = q.blk;
            loaded[q.bank * BlocksPerBank + q.lidx] = 1'b1;
            o.blk = q.blk;
         end
         MODE_ALLOC: begin
            if (free_cnt[s] == 0) o.st = ST_EMPTY;
            else begin
               o.blk = lists[slot_addr(q.bank, q.region, head_pos[s])];
               head_pos[s] = step_ring(head_pos[s], len);
               free_cnt[s]--;
            end
         end
         MODE_INC, MODE_DEC: begin
            a = q.bank * BlocksPerBank + q.blk;
            c = pages[a];
            o.blk = q.blk;
            if (q.mode == MODE_INC && c >= CountLimit) o.st = ST_LIMIT;
            else if (q.mode == MODE_DEC && c == 0) o.st = ST_ZERO;
            else begin
               c = (q.mode == MODE_INC) ? c + 1 : c - 1;
               pages[a] = c;
            end
            o.cnt = 8'(c);
         end
         MODE_COLLECT: begin
            if (free_cnt[s] >= len) o.st = ST_EMPTY;
            else begin
               best = tail_pos[s];
               bestc = pages[q.bank * BlocksPerBank +
                             lists[slot_addr(q.bank, q.region, best)]];
               i = step_ring(tail_pos[s], len);
               n = 0;
               while (i != rsv_pos[s] && n < len) begin
                  c = pages[q.bank * BlocksPerBank + lists[slot_addr(q.bank, q.region, i)]];
                  if (c < bestc) begin
                     bestc = c;
                     best = i;
                  end
                  i = step_ring(i, len);
                  n++;
               end
               swap = lists[slot_addr(q.bank, q.region, tail_pos[s])];
               o.blk = lists[slot_addr(q.bank, q.region, best)];
               lists[slot_addr(q.bank, q.region, tail_pos[s])] = o.blk;
               lists[slot_addr(q.bank, q.region, best)] = swap;
               o.cnt = 8'(bestc);
               pages[q.bank * BlocksPerBank + o.blk] = 0;
               free_cnt[s]++;
               tail_pos[s] = step_ring(tail_pos[s], len);
            end
         end
         MODE_PUSH: begin
            for (i = 0; i < Slots; i++)
               rsv_pos[i] = (head_pos[i] + region_len(1'(i % 2)) - 1) % region_len(1'(i % 2));
         end
         default: ;
      endcase
      o.gc = free_cnt[s] < thresh_cfg;
      return o;
   endfunction

   // hold the request until the block takes it, then queue the expected response
   task automatic send(input req_type q, input bit typed, input rsp_type e);
      rsp_type p;
      start <= 1'b1;
      req_mode <= q.mode;
      req_bank <= q.bank;
      req_region <= q.region;
      req_list_index <= q.lidx;
      req_block_number <= q.blk;
      do @(posedge clock); while (busy);
      p = allocate_step(q);
      pending.push_back(typed ? e : p);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input int data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 11'(data);
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_HOT: begin
            hot_cfg = data & 10'h3FF;
            reset_rings();
         end
         CSR_ENTRIES: begin
            entries_cfg = data & 11'h7FF;
            reset_rings();
         end
         default: thresh_cfg = data & 11'h7FF;
      endcase
   endtask

   function automatic bit bank_loaded(int bank);
      int e = region_len(0) + region_len(1);
      for (int i = 0; i < e; i++)
         if (!loaded[bank * BlocksPerBank + i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int first_gap(int bank);
      int e = region_len(0) + region_len(1);
      for (int i = 0; i < e; i++)
         if (!loaded[bank * BlocksPerBank + i]) return i;
      return 0;
   endfunction

   // random request; list reads go only to banks whose list is filled
   function automatic req_type pick_request();
      req_type q;
      int w = $urandom_range(0, 99);
      int s, len;
      q.bank = 2'($urandom_range(0, 3));
      q.region = 1'($urandom_range(0, 1));
      q.lidx = 10'($urandom_range(0, 1023));
      q.blk = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                          : 10'($urandom_range(0, 31));
      if (w < 30) q.mode = MODE_ALLOC;
      else if (w < 55) q.mode = MODE_COLLECT;
      else if (w < 75) q.mode = MODE_INC;
      else if (w < 85) q.mode = MODE_DEC;
      else if (w < 90) q.mode = MODE_PUSH;
      else if (w < 98) q.mode = MODE_LOAD;
      else q.mode = w[0] ? ModeSpare6 : ModeSpare7;
      s = q.bank * 2 + q.region;
      len = region_len(q.region);
      if (((q.mode == MODE_ALLOC && free_cnt[s] > 0) ||
           (q.mode == MODE_COLLECT && free_cnt[s] < len)) && !bank_loaded(q.bank)) begin
         q.mode = MODE_LOAD;
         q.lidx = 10'(first_gap(q.bank));
      end
      return q;
   endfunction

   // compare each response with the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_strobe) begin
         if (pending.size() == 0) begin
            $display("%0t: unexpected response blk=%0d cnt=%0d", $realtime,
                     rsp_result_block, rsp_valid_count);
            errors++;
         end else begin
            e = pending.pop_front();
            if (rsp_result_block !== e.blk) begin
               $display("%0t: result_block exp %0d got %0d", $realtime, e.blk, rsp_result_block);
               errors++;
            end
            if (rsp_valid_count !== e.cnt) begin
               $display("%0t: valid_count exp %0d got %0d", $realtime, e.cnt, rsp_valid_count);
               errors++;
            end
            if (rsp_gc_needed !== e.gc) begin
               $display("%0t: gc_needed exp %0b got %0b", $realtime, e.gc, rsp_gc_needed);
               errors++;
            end
            if (rsp_status !== e.st) begin
               $display("%0t: status exp %0d got %0d", $realtime, e.st, rsp_status);
               errors++;
            end
         end
      end
   end

   // stimulus: directed table, count saturation, then random phases over settings
   initial begin
      int phase_hot [8] = '{1, 1023, 3, 10, 0, 20, 7, 60};
      int phase_ent [8] = '{2, 2047, 16, 24, 0, 40, 32, 1024};
      int phase_thr [8] = '{0, 2047, 5, 1024, 3, 12, 4, 8};
      int burst, gap;
      req_type q;
      for (int i = 0; i < Banks * BlocksPerBank; i++) begin
         pages[i] = 0;
         loaded[i] = 1'b0;
         lists[i] = '0;
      end
      reset_rings();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DirTable[i]) send(DirTable[i].q, DirTable[i].typed, DirTable[i].e);

      // drive one block to the count limit and back down a little
      for (int i = 0; i < 133; i++)
         send('{(i < 130) ? MODE_INC : MODE_DEC, 2'd3, 1'b0, 10'd0, 10'd7}, 1'b0, '0);

      for (int p = 0; p < 8; p++) begin
         drain();
         csr_write(CSR_HOT, phase_hot[p]);
         csr_write(CSR_ENTRIES, phase_ent[p]);
         csr_write(CSR_THRESH, phase_thr[p]);
         csr_valid <= 1'b0;
         burst = $urandom_range(1, 20);
         for (int n = 0; n < 55; n++) begin
            q = pick_request();
            send(q, 1'b0, '0);
            if (--burst == 0) begin
               gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
               if (gap != 0) begin
                  start <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst = $urandom_range(1, 20);
            end
         end
      end

      drain();
      repeat (50) @(posedge clock);
      if (errors == 0 && pending.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // stop a hung run
   initial begin
      #100_000_000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire
